// ----- design/utf8cd_pkg.sv -----
// Package for the UTF-8 code point decoder.
// Holds the controller state, the command and status structs, constants and
// the lead-byte and CJK-range helper functions. Depends on nothing.
package utf8cd_pkg;

  localparam int unsigned CpW = 21;
  localparam logic [CpW-1:0] CP_MIN = 21'd32;

  localparam logic [CpW-1:0] CJK_A_LO = 21'h02E80;
  localparam logic [CpW-1:0] CJK_A_HI = 21'h09FFF;
  localparam logic [CpW-1:0] CJK_B_LO = 21'h0F900;
  localparam logic [CpW-1:0] CJK_B_HI = 21'h0FAFF;
  localparam logic [CpW-1:0] CJK_C_LO = 21'h0FF00;
  localparam logic [CpW-1:0] CJK_C_HI = 21'h0FFEF;

  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } utf8cd_state_e;

  typedef struct packed {
    logic accept;
    logic pop;
  } utf8cd_cmd_t;

  typedef struct packed {
    logic cand_any;
    logic pend_any;
    logic pend_more;
    logic out_free;
  } utf8cd_stat_t;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = LEN_BAD;
    if (c[7] == 1'b0)              len = LEN_1;
    else if (c[7:5] == 3'b110)     len = LEN_2;
    else if (c[7:4] == 4'b1110)    len = LEN_3;
    else if (c[7:3] == 5'b11110)   len = LEN_4;
    return len;
  endfunction

  function automatic logic [CpW-1:0] lead_bits(input logic [7:0] c, input logic [2:0] len);
    logic [CpW-1:0] v;
    case (len)
      LEN_2:   v = {10'd0, c[4:0], 6'd0};
      LEN_3:   v = {5'd0, c[3:0], 12'd0};
      LEN_4:   v = {c[2:0], 18'd0};
      default: v = {14'd0, c[6:0]};
    endcase
    return v;
  endfunction

  function automatic logic cjk_range(input logic [CpW-1:0] cp);
    return (cp >= CJK_A_LO && cp <= CJK_A_HI) ||
           (cp >= CJK_B_LO && cp <= CJK_B_HI) ||
           (cp >= CJK_C_LO && cp <= CJK_C_HI);
  endfunction

endpackage

// ----- design/utf8cd_ctrl.sv -----
// Controller for the UTF-8 code point decoder.
// Alternates between taking a byte and draining its queued results.
// Depends on utf8cd_pkg.
module utf8cd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  utf8cd_pkg::utf8cd_stat_t stat_i,
  output utf8cd_pkg::utf8cd_cmd_t  cmd_o
);
  import utf8cd_pkg::*;

  utf8cd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && stat_i.cand_any) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pend_any) state_d = ST_IDLE;
        else if (cmd_o.pop && !stat_i.pend_more) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    cmd_o.pop    = (state_q == ST_DRAIN) && stat_i.pend_any && stat_i.out_free;
  end

endmodule

// ----- design/utf8cd_dp.sv -----
// Datapath for the UTF-8 code point decoder: sequence assembly, held bytes,
// two-entry result queue, sticky CJK flag and the output register.
// Depends on utf8cd_pkg.
module utf8cd_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  utf8cd_pkg::utf8cd_cmd_t   cmd_i,
  output utf8cd_pkg::utf8cd_stat_t  stat_o,
  input  logic [7:0]                byte_in_i,
  input  logic                      end_of_string_i,
  input  logic                      clear_seen_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [20:0]               code_point_o,
  output logic                      is_cjk_o,
  output logic                      cjk_seen_o,
  output logic                      last_of_run_o
);
  import utf8cd_pkg::*;

  logic [CpW-1:0] partial_q, partial_d;
  logic [1:0]     need_q, need_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [7:0]     held_q [3];
  logic           seen_q, seen_d;

  logic [1:0]     pend_v_q, pend_v_d;
  logic [CpW-1:0] pend_cp_q [2];
  logic [CpW-1:0] pend_cp_d [2];

  logic           out_valid_q;
  logic [CpW-1:0] out_cp_q;
  logic           out_cjk_q, out_seen_q, out_last_q;

  logic [1:0]     need_dec;
  logic [CpW-1:0] cont_bits, partial_acc;
  logic [2:0]     len_b, len0, len1;
  logic [7:0]     h0;
  logic           replay;
  logic           c0_v, c1_v;
  logic [CpW-1:0] c0, c1, pair_cp;
  logic           pop_cjk;

  assign need_dec = need_q - 2'd1;
  assign len_b    = lead_len(byte_in_i);

  always_comb begin
    case (need_dec)
      2'd1:    cont_bits = {9'd0, byte_in_i[5:0], 6'd0};
      2'd2:    cont_bits = {3'd0, byte_in_i[5:0], 12'd0};
      default: cont_bits = {15'd0, byte_in_i[5:0]};
    endcase
  end
  assign partial_acc = partial_q | cont_bits;

  // Replay view: the first held byte is this byte when nothing was held yet.
  assign h0      = (cnt_q == 2'd0) ? byte_in_i : held_q[0];
  assign len0    = lead_len(h0);
  assign len1    = len_b;
  assign pair_cp = {10'd0, h0[4:0], byte_in_i[5:0]};
  assign replay  = (need_q != 2'd0) && (need_dec != 2'd0) && end_of_string_i;

  // Result candidates of the byte on the input port
  always_comb begin
    c0   = '0;
    c1   = {13'd0, byte_in_i};
    c0_v = 1'b0;
    c1_v = 1'b0;
    if (need_q != 2'd0) begin
      if (need_dec == 2'd0) begin
        c0   = partial_acc;
        c0_v = (partial_acc >= CP_MIN);
      end else if (replay) begin
        if (cnt_q == 2'd0) begin
          c0   = {13'd0, h0};
          c0_v = (len0 == LEN_1) && (c0 >= CP_MIN);
        end else if (len0 == LEN_2) begin
          c0   = pair_cp;
          c0_v = (pair_cp >= CP_MIN);
        end else begin
          c0   = {13'd0, h0};
          c0_v = (len0 == LEN_1) && (c0 >= CP_MIN);
          c1_v = (len1 == LEN_1) && (c1 >= CP_MIN);
        end
      end
    end else if (len_b == LEN_1) begin
      c0   = {13'd0, byte_in_i};
      c0_v = (c0 >= CP_MIN);
    end
  end

  assign pop_cjk = cjk_range(pend_cp_q[0]);

  // Sequence state
  always_comb begin
    partial_d = partial_q;
    need_d    = need_q;
    cnt_d     = cnt_q;
    if (cmd_i.accept) begin
      if (need_q != 2'd0) begin
        need_d    = need_dec;
        partial_d = partial_acc;
        if (cnt_q != 2'd3) cnt_d = cnt_q + 2'd1;
        if (need_dec == 2'd0) begin
          cnt_d     = 2'd0;
          partial_d = '0;
        end
      end else if (len_b >= LEN_2 && !end_of_string_i) begin
        partial_d = lead_bits(byte_in_i, len_b);
        need_d    = 2'(len_b - LEN_1);
        cnt_d     = 2'd0;
      end
      if (end_of_string_i) begin
        need_d    = 2'd0;
        cnt_d     = 2'd0;
        partial_d = '0;
      end
    end
  end

  // Result queue: load compacted on accept, shift on pop
  always_comb begin
    pend_v_d     = pend_v_q;
    pend_cp_d[0] = pend_cp_q[0];
    pend_cp_d[1] = pend_cp_q[1];
    if (cmd_i.accept) begin
      pend_v_d     = {c0_v && c1_v, c0_v || c1_v};
      pend_cp_d[0] = c0_v ? c0 : c1;
      pend_cp_d[1] = c1;
    end else if (cmd_i.pop) begin
      pend_v_d     = {1'b0, pend_v_q[1]};
      pend_cp_d[0] = pend_cp_q[1];
    end
  end

  always_comb begin
    seen_d = seen_q;
    if (cmd_i.accept && clear_seen_i) seen_d = 1'b0;
    else if (cmd_i.pop)               seen_d = seen_q | pop_cjk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      need_q      <= 2'd0;
      cnt_q       <= 2'd0;
      seen_q      <= 1'b0;
      pend_v_q    <= 2'b00;
      out_valid_q <= 1'b0;
    end else begin
      partial_q <= partial_d;
      need_q    <= need_d;
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
      pend_v_q  <= pend_v_d;
      if (cmd_i.pop)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cp_q[0] <= pend_cp_d[0];
    pend_cp_q[1] <= pend_cp_d[1];
    if (cmd_i.accept && need_q != 2'd0 && cnt_q != 2'd3) begin
      held_q[cnt_q] <= byte_in_i;
    end
    if (cmd_i.pop) begin
      out_cp_q   <= pend_cp_q[0];
      out_cjk_q  <= pop_cjk;
      out_seen_q <= seen_d;
      out_last_q <= !pend_v_q[1];
    end
  end

  assign stat_o.cand_any  = c0_v || c1_v;
  assign stat_o.pend_any  = pend_v_q[0];
  assign stat_o.pend_more = pend_v_q[1];
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = out_cp_q;
  assign is_cjk_o      = out_cjk_q;
  assign cjk_seen_o    = out_seen_q;
  assign last_of_run_o = out_last_q;

endmodule

// ----- design/utf8_codepoint_decoder.sv -----
// Top level of the UTF-8 code point decoder with CJK detection.
// Joins utf8cd_ctrl and utf8cd_dp; depends on utf8cd_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | byte_in_i, end_of_string_i, clear_seen_i
//   out     | output    | out_valid_o/out_stall_i | code_point_o, is_cjk_o, cjk_seen_o,
//           |           |                         | last_of_run_o
//
// A byte that yields no code point leaves the controller idle; a byte that yields k code
// points (k is 1 or 2) sends it to the drain state, which loads each result into the
// output register in turn. Output stall lengthens the drain.
// The output register holds a result while the next byte is taken.
// Reset clears the sequence state, the result queue and the sticky CJK flag.
module utf8_codepoint_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_string_i,
  input  logic        clear_seen_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        is_cjk_o,
  output logic        cjk_seen_o,
  output logic        last_of_run_o
);
  import utf8cd_pkg::*;

  utf8cd_cmd_t  cmd;
  utf8cd_stat_t stat;

  utf8cd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  utf8cd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .byte_in_i       (byte_in_i),
    .end_of_string_i (end_of_string_i),
    .clear_seen_i    (clear_seen_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_point_o    (code_point_o),
    .is_cjk_o        (is_cjk_o),
    .cjk_seen_o      (cjk_seen_o),
    .last_of_run_o   (last_of_run_o)
  );

  // A byte is taken only once the previous byte's results have all drained.
  a_idle_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !stat.pend_any)
    else $error("input open while results still queued");

  a_cp_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_point_o >= CP_MIN))
    else $error("code point below 32 emitted");

  a_cjk_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_cjk_o) |-> cjk_seen_o)
    else $error("CJK result without seen flag");

  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> (stat.out_free && stat.pend_any))
    else $error("result loaded over a stalled output");

endmodule
